// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// types, constants and helpers of the 2x2 modular matrix power block
// ----------------------------------------------------------------------------
package mmp_pkg;

    // matrix geometry
    localparam int DIM   = 2;
    localparam int CELLS = DIM * DIM;
    localparam int LANES = CELLS * DIM;

    // field widths
    localparam int ELEM_W = 31;
    localparam int EXP_W  = 63;

    // one serial step per multiplier bit
    localparam int STEPS = ELEM_W;
    localparam int CNT_W = $clog2(STEPS);

    localparam logic [ELEM_W-1:0] MOD_RESET = ELEM_W'(1000000007);
    localparam logic [ELEM_W-1:0] MOD_MIN   = ELEM_W'(2);

    typedef logic [ELEM_W-1:0] t_elem;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } t_state;

    // matrix operation in progress
    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

    // lane control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctrl;

    // (a + b) mod m for a, b below m
    function automatic t_elem f_addmod(input t_elem a, input t_elem b, input t_elem m);
        logic [ELEM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[ELEM_W-1:0];
    endfunction

endpackage

// File: rtl/modular_matrix_power_2x2.sv
// ----------------------------------------------------------------------------
// modular_matrix_power_2x2
// raises a 2x2 matrix to a 63-bit power modulo a configured modulus
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  start     in         i_start & !o_busy         entries 00..11, exponent
//  result    out        o_done, one-cycle strobe  power 00..11
//  config    in         i_cfg_valid & o_cfg_ready modulus, idle and no start
//
//  each matrix product is a lane load, 31 serial steps in the eight
//  bit-serial multiplier lanes and a write-back of the summed terms.
//  an item is a reduction pass, a multiply per set exponent bit and a
//  squaring between bits; a zero exponent or a modulus below two skips
//  them. o_busy stays high until the strobe cycle ends.
//  reset is synchronous; it idles the sequencer and reloads the modulus.
//  the receiver cannot stall: the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_matrix_power_2x2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [mmp_pkg::ELEM_W-1:0]   i_entry_00,
    input  logic [mmp_pkg::ELEM_W-1:0]   i_entry_01,
    input  logic [mmp_pkg::ELEM_W-1:0]   i_entry_10,
    input  logic [mmp_pkg::ELEM_W-1:0]   i_entry_11,
    input  logic [mmp_pkg::EXP_W-1:0]    i_exponent,
    output logic                         o_done,
    output logic [mmp_pkg::ELEM_W-1:0]   o_power_00,
    output logic [mmp_pkg::ELEM_W-1:0]   o_power_01,
    output logic [mmp_pkg::ELEM_W-1:0]   o_power_10,
    output logic [mmp_pkg::ELEM_W-1:0]   o_power_11,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mmp_pkg::ELEM_W-1:0]   i_cfg_data
);
    import mmp_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_op              r_op;
    t_op              n_op;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [EXP_W-1:0] r_exp;
    logic [EXP_W-1:0] n_exp;
    t_elem            r_modulus;
    t_elem            n_modulus;
    t_elem            r_base  [CELLS];
    t_elem            n_base  [CELLS];
    t_elem            r_accum [CELLS];
    t_elem            n_accum [CELLS];
    t_elem            w_entry [CELLS];
    t_elem            w_add   [LANES];
    t_elem            w_ser   [LANES];
    t_elem            w_prod  [LANES];
    t_elem            w_sum   [CELLS];
    t_lane_ctrl       w_ctrl;

    assign w_entry[0] = i_entry_00;
    assign w_entry[1] = i_entry_01;
    assign w_entry[2] = i_entry_10;
    assign w_entry[3] = i_entry_11;

    // lanes: in a product, lane (i, j, k) forms left[i][k] * right[k][j]
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int LI = l / CELLS;
        localparam int LJ = (l / DIM) % DIM;
        localparam int LK = l % DIM;

        // operand selection per operation
        always_comb begin
            unique case (r_op)
                OP_MUL: begin
                    w_add[l] = r_accum[LI*DIM+LK];
                    w_ser[l] = r_base[LK*DIM+LJ];
                end
                OP_SQR: begin
                    w_add[l] = r_base[LI*DIM+LK];
                    w_ser[l] = r_base[LK*DIM+LJ];
                end
                default: begin
                    w_add[l] = ELEM_W'(1);
                    w_ser[l] = r_base[l%CELLS];
                end
            endcase
        end

        mmp_mulmod_lane u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_modulus (r_modulus),
            .i_addend  (w_add[l]),
            .i_serial  (w_ser[l]),
            .o_product (w_prod[l])
        );
    end

    // sum the two terms of each product entry
    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            w_sum[c] = f_addmod(w_prod[c*DIM], w_prod[c*DIM+1], r_modulus);
        end
    end

    // sequencer: next state and lane control
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_exp     = r_exp;
        n_modulus = r_modulus;
        n_base    = r_base;
        n_accum   = r_accum;
        w_ctrl    = '0;

        // config word
        if (i_cfg_valid && o_cfg_ready) begin
            n_modulus = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_exp = i_exponent;
                    for (int c = 0; c < CELLS; c++) begin
                        n_base[c]  = w_entry[c];
                        n_accum[c] = ((c / DIM) == (c % DIM)) ? ELEM_W'(1) : '0;
                    end
                    priority if (r_modulus < MOD_MIN) begin
                        for (int c = 0; c < CELLS; c++) begin
                            n_accum[c] = '0;
                        end
                        n_state = ST_DONE;
                    end else if (i_exponent == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_op    = OP_RED;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_cnt       = '0;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_LOAD;
                unique case (r_op)
                    OP_MUL: begin
                        n_accum = w_sum;
                        n_exp   = r_exp >> 1;
                        if (r_exp[EXP_W-1:1] == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_op = OP_SQR;
                        end
                    end
                    default: begin
                        // reduction pass or squaring, then the next exponent bit
                        if (r_op == OP_RED) begin
                            for (int c = 0; c < CELLS; c++) begin
                                n_base[c] = w_prod[c];
                            end
                        end else begin
                            n_base = w_sum;
                        end
                        if (r_exp[0]) begin
                            n_op = OP_MUL;
                        end else begin
                            n_exp = r_exp >> 1;
                            n_op  = OP_SQR;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_RED;
            r_cnt     <= '0;
            r_exp     <= '0;
            r_modulus <= MOD_RESET;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_exp     <= n_exp;
            r_modulus <= n_modulus;
        end
    end

    // matrix registers
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_accum <= n_accum;
    end

    // ports
    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = (r_state == ST_DONE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;
    assign o_power_00  = r_accum[0];
    assign o_power_01  = r_accum[1];
    assign o_power_10  = r_accum[2];
    assign o_power_11  = r_accum[3];

    // checks
    `ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted word left block idle")
    `ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == ST_RUN, r_cnt < CNT_W'(STEPS), "serial step count overrun")
    `ASSERT_NXT(a_fin_after_run, i_clk, i_rst_n, r_state == ST_RUN && r_cnt == CNT_W'(STEPS - 1), r_state == ST_FIN, "write-back missed after last step")

endmodule

// File: rtl/mmp_mulmod_lane.sv
// ----------------------------------------------------------------------------
// mmp_mulmod_lane
// bit-serial modular multiplier, one multiplier bit per cycle while step is set, msb first
// ----------------------------------------------------------------------------
module mmp_mulmod_lane (
    input  logic                i_clk,
    input  mmp_pkg::t_lane_ctrl i_ctrl,
    input  mmp_pkg::t_elem      i_modulus,
    input  mmp_pkg::t_elem      i_addend,
    input  mmp_pkg::t_elem      i_serial,
    output mmp_pkg::t_elem      o_product
);
    import mmp_pkg::*;

    t_elem r_acc;
    t_elem r_add;
    t_elem r_sh;
    t_elem n_acc;
    t_elem n_add;
    t_elem n_sh;
    t_elem w_dbl;

    // double the partial product, then add the addend when the bit is set
    always_comb begin
        n_acc = r_acc;
        n_add = r_add;
        n_sh  = r_sh;
        w_dbl = f_addmod(r_acc, r_acc, i_modulus);
        priority if (i_ctrl.load) begin
            n_acc = '0;
            n_add = i_addend;
            n_sh  = i_serial;
        end else if (i_ctrl.step) begin
            n_acc = r_sh[ELEM_W-1] ? f_addmod(w_dbl, r_add, i_modulus) : w_dbl;
            n_sh  = {r_sh[ELEM_W-2:0], 1'b0};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_add <= n_add;
        r_sh  <= n_sh;
    end

    assign o_product = r_acc;

endmodule

// File: sim/mmp_power_checker.sv
// ----------------------------------------------------------------------------
// mmp_power_checker
// watches the start, result and config channels of the 2x2 matrix power
// block, predicts each power from the accepted word and the current modulus,
// and compares every result strobe against the oldest prediction
// ----------------------------------------------------------------------------
module mmp_power_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  mmp_pkg::t_elem                i_entry_00,
    input  mmp_pkg::t_elem                i_entry_01,
    input  mmp_pkg::t_elem                i_entry_10,
    input  mmp_pkg::t_elem                i_entry_11,
    input  logic [mmp_pkg::EXP_W-1:0]     i_exponent,
    input  logic                          i_done,
    input  mmp_pkg::t_elem                i_power_00,
    input  mmp_pkg::t_elem                i_power_01,
    input  mmp_pkg::t_elem                i_power_10,
    input  mmp_pkg::t_elem                i_power_11,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  mmp_pkg::t_elem                i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import mmp_pkg::*;

    // one 2x2 matrix, row-major
    typedef struct packed {
        t_elem e00;
        t_elem e01;
        t_elem e10;
        t_elem e11;
    } t_mat2;

    t_elem modulus_reg;
    t_mat2 expected_powers[$];
    int    error_cnt;
    int    pending_cnt;
    int    checked_cnt;

    assign o_errors  = error_cnt;
    assign o_pending = pending_cnt;
    assign o_checked = checked_cnt;

    initial begin
        modulus_reg = MOD_RESET;
        error_cnt   = 0;
        pending_cnt = 0;
        checked_cnt = 0;
    end

    // (a0 * b0 mod m + a1 * b1 mod m) mod m, all in 64 bits
    function automatic t_elem dot2_mod(input t_elem a0, input t_elem b0,
                                       input t_elem a1, input t_elem b1,
                                       input t_elem m);
        logic [63:0] m64;
        logic [63:0] acc;
        m64 = 64'(m);
        acc = (64'(a0) * 64'(b0)) % m64;
        acc = (acc + (64'(a1) * 64'(b1)) % m64) % m64;
        return t_elem'(acc);
    endfunction

    function automatic t_mat2 mat_mul_mod(input t_mat2 l, input t_mat2 r, input t_elem m);
        t_mat2 p;
        p.e00 = dot2_mod(l.e00, r.e00, l.e01, r.e10, m);
        p.e01 = dot2_mod(l.e00, r.e01, l.e01, r.e11, m);
        p.e10 = dot2_mod(l.e10, r.e00, l.e11, r.e10, m);
        p.e11 = dot2_mod(l.e10, r.e01, l.e11, r.e11, m);
        return p;
    endfunction

    // right-to-left square and multiply from the identity
    function automatic t_mat2 mod_matrix_power(input t_mat2 base_in,
                                               input logic [EXP_W-1:0] e,
                                               input t_elem m);
        t_mat2            acc;
        t_mat2            sq;
        logic [EXP_W-1:0] bits_left;
        if (m < MOD_MIN) begin
            return '0;
        end
        acc       = '{t_elem'(1), t_elem'(0), t_elem'(0), t_elem'(1)};
        sq        = base_in;
        bits_left = e;
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                acc = mat_mul_mod(acc, sq, m);
            end
            bits_left = bits_left >> 1;
            sq        = mat_mul_mod(sq, sq, m);
        end
        return acc;
    endfunction

    task automatic check_field(input string name, input t_elem want, input t_elem got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_cnt++;
        end
    endtask

    // sample all three channels on the rising edge
    always @(posedge i_clk) begin : watch
        t_mat2 want;
        t_mat2 word;
        if (!i_rst_n) begin
            modulus_reg = MOD_RESET;
            expected_powers.delete();
        end else begin
            // result word against the oldest prediction
            if (i_done) begin
                if (expected_powers.size() == 0) begin
                    $error("result strobe with no word outstanding");
                    error_cnt++;
                end else begin
                    want = expected_powers.pop_front();
                    check_field("power_00", want.e00, i_power_00);
                    check_field("power_01", want.e01, i_power_01);
                    check_field("power_10", want.e10, i_power_10);
                    check_field("power_11", want.e11, i_power_11);
                    checked_cnt++;
                end
            end
            // accepted start word
            if (i_start && !i_busy) begin
                word = '{i_entry_00, i_entry_01, i_entry_10, i_entry_11};
                expected_powers.insert(expected_powers.size(),
                                       mod_matrix_power(word, i_exponent, modulus_reg));
            end
            // modulus write
            if (i_cfg_valid && i_cfg_ready) begin
                modulus_reg = i_cfg_data;
            end
        end
        pending_cnt = expected_powers.size();
    end

endmodule

// File: sim/tb_modular_matrix_power_2x2.sv
// ----------------------------------------------------------------------------
// tb_modular_matrix_power_2x2
// drives directed and random matrix/exponent words through the block over a
// series of modulus settings (reset value, 2^31-1, 2, 0, 1, 97, random), with
// random bursts and gaps on the start channel; the checker predicts and
// compares, this module makes stimulus and reports the verdict
// ----------------------------------------------------------------------------
module tb_modular_matrix_power_2x2;
    timeunit 1ns;
    timeprecision 1ps;
    import mmp_pkg::*;

    localparam logic [EXP_W-1:0] EXP_MAX  = '1;
    localparam t_elem            ELEM_MAX = '1;
    // longer than the slowest item
    localparam int               TAIL_CYCLES = 4200;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    t_elem            entry_00;
    t_elem            entry_01;
    t_elem            entry_10;
    t_elem            entry_11;
    logic [EXP_W-1:0] exponent;
    logic             done;
    t_elem            power_00;
    t_elem            power_01;
    t_elem            power_10;
    t_elem            power_11;
    logic             cfg_valid;
    logic             cfg_ready;
    t_elem            cfg_data;

    int    fail_count;
    int    pending_count;
    int    checked_count;
    int    items_sent;
    t_elem modulus_now;

    modular_matrix_power_2x2 uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_entry_00  (entry_00),
        .i_entry_01  (entry_01),
        .i_entry_10  (entry_10),
        .i_entry_11  (entry_11),
        .i_exponent  (exponent),
        .o_done      (done),
        .o_power_00  (power_00),
        .o_power_01  (power_01),
        .o_power_10  (power_10),
        .o_power_11  (power_11),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mmp_power_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_entry_00  (entry_00),
        .i_entry_01  (entry_01),
        .i_entry_10  (entry_10),
        .i_entry_11  (entry_11),
        .i_exponent  (exponent),
        .i_done      (done),
        .i_power_00  (power_00),
        .i_power_01  (power_01),
        .i_power_10  (power_10),
        .i_power_11  (power_11),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(64'd50_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // present one word and hold start until the block takes it
    task automatic send_matrix(input t_elem a00, input t_elem a01,
                               input t_elem a10, input t_elem a11,
                               input logic [EXP_W-1:0] e);
        @(negedge clk);
        entry_00 = a00;
        entry_01 = a01;
        entry_10 = a10;
        entry_11 = a11;
        exponent = e;
        start    = 1'b1;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // drop start, with junk on the word ports
    task automatic pause(input int n);
        @(negedge clk);
        start    = 1'b0;
        entry_00 = t_elem'($urandom);
        entry_01 = t_elem'($urandom);
        entry_10 = t_elem'($urandom);
        entry_11 = t_elem'($urandom);
        exponent = EXP_W'({$urandom, $urandom});
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending until every outstanding word has come back
    task automatic drain();
        pause(1);
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_modulus(input t_elem value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid   = 1'b0;
        modulus_now = value;
    endtask

    // mostly below the modulus, some zero, top, or above the modulus
    function automatic t_elem pick_entry();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return ELEM_MAX;
        end else if (sel == 2 || modulus_now == '0) begin
            return t_elem'($urandom);
        end else if (sel == 3) begin
            return modulus_now - t_elem'(1);
        end
        return t_elem'($urandom_range(32'(modulus_now) - 1));
    endfunction

    // random bit length from 1 to 63 bits; some zero, a few full width
    function automatic logic [EXP_W-1:0] pick_exponent();
        int          len;
        logic [63:0] raw;
        len = ($urandom_range(15) == 0) ? 0 : $urandom_range(EXP_W, 1);
        raw = {$urandom, $urandom};
        if (len == 0) begin
            return '0;
        end
        raw = raw & ((64'd1 << len) - 64'd1);
        raw[len-1] = 1'b1;
        return raw[EXP_W-1:0];
    endfunction

    // random bursts with random gaps between them
    task automatic random_items(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(8, 1);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) begin
                send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                            pick_exponent());
            end
            left -= burst;
            case ($urandom_range(9))
                0:       drain();
                1, 2:    pause($urandom_range(TAIL_CYCLES, 1));
                3:       ;
                default: pause($urandom_range(12, 1));
            endcase
        end
    endtask

    task automatic run_phase(input t_elem m, input int n);
        drain();
        write_modulus(m);
        random_items(n);
    endtask

    // corner words under the reset modulus, back to back
    task automatic directed_items();
        t_elem top;
        top = MOD_RESET - t_elem'(1);
        // zero exponent gives the identity
        send_matrix('0, '0, '0, '0, '0);
        send_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, '0);
        // entries above the modulus
        send_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 63'd1);
        send_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, EXP_MAX);
        // fibonacci q-matrix
        send_matrix(31'd1, 31'd1, 31'd1, 31'd0, 63'd90);
        send_matrix(31'd1, 31'd1, 31'd1, 31'd0, EXP_MAX);
        send_matrix(top, top, top, top, 63'd2);
        send_matrix(31'd1, 31'd0, 31'd0, 31'd1, EXP_MAX);
        send_matrix('0, '0, '0, '0, 63'd1);
        send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry(), 63'd1 << 62);
        // swap matrix, odd power
        send_matrix(31'd0, 31'd1, 31'd1, 31'd0, 63'd3);
        send_matrix(31'd2, 31'd0, 31'd0, 31'd3, 63'd40);
        send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                    63'h5555_5555_5555_5555);
        send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                    63'h2AAA_AAAA_AAAA_AAAA);
        send_matrix(31'd1, 31'd1, 31'd0, 31'd1, 63'd1_000_000);
        send_matrix(top, 31'd0, 31'd1, top, EXP_MAX - 1);
    endtask

    initial begin
        rst_n       = 1'b0;
        start       = 1'b0;
        entry_00    = '0;
        entry_01    = '0;
        entry_10    = '0;
        entry_11    = '0;
        exponent    = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        items_sent  = 0;
        modulus_now = MOD_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();
        // extremes, then out-of-range moduli, then ordinary settings
        run_phase(ELEM_MAX, 35);
        run_phase(MOD_MIN, 15);
        run_phase(t_elem'(0), 5);
        run_phase(t_elem'(1), 5);
        run_phase(t_elem'($urandom_range(32'h7FFF_FFFE, 3)), 30);
        run_phase(t_elem'(97), 20);
        run_phase(MOD_RESET, 30);

        // let any stray strobe show up before the verdict
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("summary: %0d words sent, %0d results checked, %0d mismatches",
                 items_sent, checked_count, fail_count);
        $display("moduli covered: reset value, 2^31-1, 2, 0, 1, 97 and one random");
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: modular_matrix_power_2x2.f
+incdir+rtl
rtl/mmp_pkg.sv
rtl/mmp_mulmod_lane.sv
rtl/modular_matrix_power_2x2.sv
sim/mmp_power_checker.sv
sim/tb_modular_matrix_power_2x2.sv
